// ===== sv/lcmt_pkg.sv =====
// Shared constants for the minimum line tree.
package lcmt_pkg;

  localparam int DOMAIN_SIZE_DEF = 1024;
  localparam int SLOPE_BITS_DEF  = 32;
  localparam int INTERCEPT_W     = 63;
  localparam int VALUE_W         = 64;
  localparam int QX_W            = 10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = 64'sd1000000000000000000;

endpackage

// ===== sv/li_chao_min_line_tree.sv =====
// Top level of the minimum line tree: sequencer, node store and evaluator.
//
// Usage:
//   Present an item on operation, slope, intercept and query_x with start high;
//   it is accepted at a rising edge where start is high and busy is low.
//   An insert item (operation 0) stores a line and returns nothing. A query
//   item (operation 1) returns the lowest line value at query_x on min_value,
//   marked by a one-cycle done strobe; 1e18 when no line covers the path.
//   Each tree level is a node store read, then compare and write back. An
//   insert keeps busy high through all log2(DOMAIN_SIZE) + 1 levels, then
//   busy is low in the idle state, where the next item can be accepted.
//   A query visits each populated level on its path, plus one extra read
//   when the path ends at an absent node; its done strobe is registered and
//   comes in the cycle after the last level; busy is low then,
//   so the next item may be accepted while the result is shown.
//   The receiver cannot stall: done lasts exactly one cycle.
//   After reset the node store is cleared, one entry per cycle, through all
//   2 * 2^ceil(log2(DOMAIN_SIZE)) entries (2048 by default); busy is high
//   throughout.
module li_chao_min_line_tree #(
  parameter int DOMAIN_SIZE = lcmt_pkg::DOMAIN_SIZE_DEF,
  parameter int SLOPE_BITS  = lcmt_pkg::SLOPE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    operation,
  input  logic signed [SLOPE_BITS-1:0]            slope,
  input  logic signed [lcmt_pkg::INTERCEPT_W-1:0] intercept,
  input  logic [lcmt_pkg::QX_W-1:0]               query_x,
  output logic                                    done,
  output logic signed [lcmt_pkg::VALUE_W-1:0]     min_value
);
  import lcmt_pkg::*;

  localparam int IDX_W      = $clog2(DOMAIN_SIZE) + 1;
  localparam int NODE_DEPTH = 2 ** IDX_W;
  localparam int POS_W      = $clog2(DOMAIN_SIZE + 1);
  localparam int WORD_W     = 1 + SLOPE_BITS + INTERCEPT_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_MUL   = 4'b0100,
    S_CMP   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic                          op;
  logic signed [SLOPE_BITS-1:0]  new_slope, par_slope, node_slope;
  logic signed [INTERCEPT_W-1:0] new_int, par_int, node_int;
  logic [IDX_W-1:0]              idx, clr_addr, child_idx;
  logic [POS_W-1:0]              lo, hi, mid, qx;
  logic signed [VALUE_W-1:0]     best, best_next;

  logic                          we;
  logic [IDX_W-1:0]              waddr, raddr;
  logic [WORD_W-1:0]             wdata, rdata;

  logic                          rd_present;
  logic signed [SLOPE_BITS-1:0]  cur_slope, kept_slope, other_slope;
  logic signed [INTERCEPT_W-1:0] cur_int, kept_int, other_int;
  logic signed [VALUE_W-1:0]     a0_val, a1_val, b0_val, b1_val;
  logic                          swap, go_left, unit, accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign rd_present = rdata[WORD_W-1];
  assign cur_slope  = rd_present ? rdata[WORD_W-2 -: SLOPE_BITS] : par_slope;
  assign cur_int    = rd_present ? rdata[INTERCEPT_W-1:0] : par_int;

  lcmt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NODE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  lcmt_eval #(
    .SLOPE_BITS(SLOPE_BITS),
    .POS_W     (POS_W)
  ) u_eval (
    .clk    (clk),
    .a_slope(cur_slope),
    .a_int  (cur_int),
    .b_slope(new_slope),
    .b_int  (new_int),
    .p0     ((op == OP_QUERY) ? qx : mid),
    .p1     (lo),
    .a0_val (a0_val),
    .a1_val (a1_val),
    .b0_val (b0_val),
    .b1_val (b1_val)
  );

  assign swap        = (a0_val > b0_val);
  assign kept_slope  = swap ? new_slope : node_slope;
  assign kept_int    = swap ? new_int : node_int;
  assign other_slope = swap ? node_slope : new_slope;
  assign other_int   = swap ? node_int : new_int;
  assign unit        = ((hi - lo) <= POS_W'(1));
  assign go_left     = (op == OP_QUERY) ? (qx < mid) :
                       (swap ? (b1_val > a1_val) : (a1_val > b1_val));
  assign child_idx   = {idx[IDX_W-2:0], !go_left};
  assign best_next   = (a0_val < best) ? a0_val : best;

  assign we    = (state == S_CLEAR) || ((state == S_CMP) && (op == OP_INSERT));
  assign waddr = (state == S_CLEAR) ? clr_addr : idx;
  assign wdata = (state == S_CLEAR) ? '0 : {1'b1, kept_slope, kept_int};
  assign raddr = (state == S_IDLE) ? IDX_W'(1) : child_idx;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if ((op == OP_QUERY) && !rd_present) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = unit ? S_IDLE : S_MUL;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if ((state == S_MUL) && (op == OP_QUERY) && !rd_present) begin
        done <= 1'b1;
      end
      if ((state == S_CMP) && (op == OP_QUERY) && unit) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op        <= operation;
          new_slope <= slope;
          new_int   <= intercept;
          qx        <= POS_W'(query_x);
          par_slope <= '0;
          par_int   <= INTERCEPT_W'(EMPTY_VALUE);
          best      <= EMPTY_VALUE;
          idx       <= IDX_W'(1);
          lo        <= '0;
          hi        <= POS_W'(DOMAIN_SIZE);
          mid       <= POS_W'(DOMAIN_SIZE / 2);
        end
      end
      S_MUL: begin
        node_slope <= cur_slope;
        node_int   <= cur_int;
        if ((op == OP_QUERY) && !rd_present) begin
          min_value <= best;
        end
      end
      S_CMP: begin
        best <= best_next;
        if ((op == OP_QUERY) && unit) begin
          min_value <= best_next;
        end
        if (op == OP_INSERT) begin
          par_slope <= kept_slope;
          par_int   <= kept_int;
          new_slope <= other_slope;
          new_int   <= other_int;
        end
        idx <= child_idx;
        if (go_left) begin
          hi  <= mid;
          mid <= lo + ((mid - lo) >> 1);
        end else begin
          lo  <= mid;
          mid <= mid + ((hi - mid) >> 1);
        end
      end
      default: begin
      end
    endcase
  end

  a_done_query: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(op) == OP_QUERY) && ($past(state) == S_MUL || $past(state) == S_CMP))
    else $error("result strobe without a finished query");

  a_insert_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && op == OP_INSERT) |=> !done)
    else $error("insert item produced a result");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MUL) && (idx == IDX_W'(1)))
    else $error("accepted item did not start at the root");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CLEAR) || (state == S_CMP && op == OP_INSERT))
    else $error("store written outside clear or insert compare");

endmodule

// ===== sv/lcmt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lcmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lcmt_eval.sv =====
// Two-line evaluator: registered products at two points, then intercept add.
module lcmt_eval #(
  parameter int SLOPE_BITS = 32,
  parameter int POS_W      = 11
) (
  input  logic                                   clk,
  input  logic signed [SLOPE_BITS-1:0]           a_slope,
  input  logic signed [lcmt_pkg::INTERCEPT_W-1:0] a_int,
  input  logic signed [SLOPE_BITS-1:0]           b_slope,
  input  logic signed [lcmt_pkg::INTERCEPT_W-1:0] b_int,
  input  logic [POS_W-1:0]                       p0,
  input  logic [POS_W-1:0]                       p1,
  output logic signed [lcmt_pkg::VALUE_W-1:0]     a0_val,
  output logic signed [lcmt_pkg::VALUE_W-1:0]     a1_val,
  output logic signed [lcmt_pkg::VALUE_W-1:0]     b0_val,
  output logic signed [lcmt_pkg::VALUE_W-1:0]     b1_val
);
  import lcmt_pkg::*;

  localparam int PROD_W = SLOPE_BITS + POS_W + 1;
  localparam int EXT_W  = VALUE_W - PROD_W;

  logic signed [PROD_W-1:0]      a0_prod, a1_prod, b0_prod, b1_prod;
  logic signed [INTERCEPT_W-1:0] a_int_q, b_int_q;

  always_ff @(posedge clk) begin
    a0_prod <= a_slope * $signed({1'b0, p0});
    a1_prod <= a_slope * $signed({1'b0, p1});
    b0_prod <= b_slope * $signed({1'b0, p0});
    b1_prod <= b_slope * $signed({1'b0, p1});
    a_int_q <= a_int;
    b_int_q <= b_int;
  end

  assign a0_val = {{EXT_W{a0_prod[PROD_W-1]}}, a0_prod} + {a_int_q[INTERCEPT_W-1], a_int_q};
  assign a1_val = {{EXT_W{a1_prod[PROD_W-1]}}, a1_prod} + {a_int_q[INTERCEPT_W-1], a_int_q};
  assign b0_val = {{EXT_W{b0_prod[PROD_W-1]}}, b0_prod} + {b_int_q[INTERCEPT_W-1], b_int_q};
  assign b1_val = {{EXT_W{b1_prod[PROD_W-1]}}, b1_prod} + {b_int_q[INTERCEPT_W-1], b_int_q};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the minimum line tree: directed and random inserts and queries.
module tb;
  import lcmt_pkg::*;

  localparam int DOMAIN     = DOMAIN_SIZE_DEF;
  localparam int TREE_NODES = 2 * DOMAIN;
  localparam int RAND_ITEMS = 450;
  localparam int LIMIT      = 400000;

  class envelope_scoreboard;
    longint node_m    [TREE_NODES];
    longint node_c    [TREE_NODES];
    bit     node_seen [TREE_NODES];
    longint expected_min [$];
    int     errors = 0;

    function longint line_value(longint m, longint c, longint x);
      return m * x + c;
    endfunction

    function void note_item(logic op, logic signed [SLOPE_BITS_DEF-1:0] s,
                            logic signed [INTERCEPT_W-1:0] c_in, logic [QX_W-1:0] qx);
      longint m, c, lo, hi, mid, km, kc, pm, pc, tm, tc, best, v, x;
      int idx;
      if (op == OP_INSERT) begin
        m = s;
        c = c_in;
        lo = 0;
        hi = DOMAIN;
        idx = 1;
        pm = 0;
        pc = EMPTY_VALUE;
        while (idx < TREE_NODES) begin
          if (!node_seen[idx]) begin
            node_seen[idx] = 1'b1;
            node_m[idx] = pm;
            node_c[idx] = pc;
          end
          mid = lo + (hi - lo) / 2;
          km = node_m[idx];
          kc = node_c[idx];
          if (line_value(km, kc, mid) > line_value(m, c, mid)) begin
            tm = km;
            tc = kc;
            km = m;
            kc = c;
            m = tm;
            c = tc;
            node_m[idx] = km;
            node_c[idx] = kc;
          end
          if (hi - lo <= 1) break;
          pm = km;
          pc = kc;
          if (line_value(km, kc, lo) > line_value(m, c, lo)) begin
            idx = 2 * idx;
            hi = mid;
          end else begin
            idx = 2 * idx + 1;
            lo = mid;
          end
        end
      end else begin
        x = qx;
        best = EMPTY_VALUE;
        lo = 0;
        hi = DOMAIN;
        idx = 1;
        while (idx < TREE_NODES && node_seen[idx]) begin
          v = line_value(node_m[idx], node_c[idx], x);
          if (v < best) best = v;
          if (hi - lo <= 1) break;
          mid = lo + (hi - lo) / 2;
          if (x < mid) begin
            idx = 2 * idx;
            hi = mid;
          end else begin
            idx = 2 * idx + 1;
            lo = mid;
          end
        end
        expected_min.push_back(best);
      end
    endfunction

    function void check_min_value(logic signed [VALUE_W-1:0] actual);
      longint want;
      if (expected_min.size() == 0) begin
        $error("min_value: expected none, actual %0d", actual);
        errors++;
      end else begin
        want = expected_min.pop_front();
        if (actual !== want) begin
          $error("min_value: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = OP_INSERT;
  logic signed [SLOPE_BITS_DEF-1:0] slope = '0;
  logic signed [INTERCEPT_W-1:0] intercept = '0;
  logic [QX_W-1:0] query_x = '0;
  logic busy;
  logic done;
  logic signed [VALUE_W-1:0] min_value;

  envelope_scoreboard sb = new();
  int idle_pct = 14;
  int cycle_count = 0;

  li_chao_min_line_tree u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .slope     (slope),
    .intercept (intercept),
    .query_x   (query_x),
    .done      (done),
    .min_value (min_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_min_value(min_value);
  end

  task automatic drive_item(input logic op, input logic signed [SLOPE_BITS_DEF-1:0] s,
                            input logic signed [INTERCEPT_W-1:0] c, input logic [QX_W-1:0] x);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    slope <= s;
    intercept <= c;
    query_x <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, s, c, x);
  endtask

  task automatic add_line(input logic signed [SLOPE_BITS_DEF-1:0] s,
                          input logic signed [INTERCEPT_W-1:0] c);
    drive_item(OP_INSERT, s, c, QX_W'($urandom));
  endtask

  task automatic ask_min(input logic [QX_W-1:0] x);
    drive_item(OP_QUERY, $urandom, INTERCEPT_W'({$urandom, $urandom}), x);
  endtask

  task automatic random_line();
    int mode;
    logic signed [SLOPE_BITS_DEF-1:0] s;
    logic signed [INTERCEPT_W-1:0] c;
    mode = $urandom_range(9);
    if (mode < 2) begin
      s = $urandom;
      c = INTERCEPT_W'({$urandom, $urandom});
    end else if (mode < 4) begin
      s = SLOPE_BITS_DEF'(longint'($urandom_range(2097152)) - 1048576);
      c = INTERCEPT_W'(longint'({$urandom_range(1023), $urandom}) - 64'sd549755813888);
    end else begin
      s = SLOPE_BITS_DEF'(longint'($urandom_range(2000)) - 1000);
      c = INTERCEPT_W'(longint'($urandom_range(2000000)) - 1000000);
    end
    add_line(s, c);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ask_min('0);
    ask_min('1);
    add_line({1'b0, {(SLOPE_BITS_DEF-1){1'b1}}}, {1'b1, {(INTERCEPT_W-1){1'b0}}});
    ask_min('0);
    ask_min('1);
    add_line({1'b1, {(SLOPE_BITS_DEF-1){1'b0}}}, {1'b0, {(INTERCEPT_W-1){1'b1}}});
    ask_min('0);
    ask_min(10'd512);
    ask_min('1);
    add_line('0, '0);
    add_line(32'sd1, -63'sd5);
    add_line(-32'sd1, 63'sd1023);
    add_line(32'sd1, -63'sd5);
    add_line(32'sd3, -63'sd2000);
    ask_min(10'd0);
    ask_min(10'd1);
    ask_min(10'd511);
    ask_min(10'd512);
    ask_min(10'd700);
    ask_min(10'd1022);
    ask_min(10'd1023);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_pct = (i < RAND_ITEMS / 3) ? 14 : (i < 2 * RAND_ITEMS / 3) ? 67 : 0;
      if ($urandom_range(99) < 45) begin
        case ($urandom_range(9))
          0: ask_min('0);
          1: ask_min('1);
          default: ask_min(QX_W'($urandom_range(DOMAIN - 1)));
        endcase
      end else begin
        random_line();
      end
    end
    start <= 1'b0;

    while (sb.expected_min.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/lcmt_pkg.sv
sv/lcmt_ram.sv
sv/lcmt_eval.sv
sv/li_chao_min_line_tree.sv
tb/tb.sv
